FILE: rtl/core/crfab_pkg.sv
// ----------------------------------------------------------------------------
// crfab_pkg
// Shared types and constants for the clipped rectangle fill and blend engine.
// ----------------------------------------------------------------------------
package crfab_pkg;

    localparam int CW = 16;
    typedef logic signed [CW-1:0] coord_t;

    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_VLINE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 12;
    typedef logic [CFG_IW-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CLIP_X_MIN = 3'd0;
    localparam cfg_idx_t CFG_CLIP_X_MAX = 3'd1;
    localparam cfg_idx_t CFG_CLIP_Y_MIN = 3'd2;
    localparam cfg_idx_t CFG_CLIP_Y_MAX = 3'd3;
    localparam cfg_idx_t CFG_ORIGIN_X   = 3'd4;
    localparam cfg_idx_t CFG_ORIGIN_Y   = 3'd5;

    localparam logic [7:0]  CLIP_X_MAX_RST = 8'd128;
    localparam logic [6:0]  CLIP_Y_MAX_RST = 7'd64;

    localparam logic [3:0]  OPAQUE_LEVEL = 4'd15;
    localparam logic [13:0] COUNT_MAX    = 14'h3fff;

    // x / 15 as (x * 2185) >> 15, exact for x below 1024
    localparam logic [11:0] DIV15_RECIP = 12'd2185;
    localparam int          DIV15_SHIFT = 15;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic signed [11:0] span_w;
        logic signed [11:0] span_h;
        logic [15:0]        fill_color;
        logic [3:0]         opacity;
        logic               pattern;
    } req_t;

    typedef struct packed {
        logic [15:0] read_color;
        logic [13:0] pixels_written;
        logic        clipped_out;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OFFSET,
        ST_FLIP,
        ST_CLIP,
        ST_CHECK,
        ST_RADDR,
        ST_RISSUE,
        ST_RWAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    function automatic coord_t sext12(input logic [11:0] v);
        return {{(CW-12){v[11]}}, v};
    endfunction

endpackage

FILE: rtl/core/crfab_ram.sv
// ----------------------------------------------------------------------------
// crfab_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module crfab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/crfab_blend.sv
// ----------------------------------------------------------------------------
// crfab_blend
// Two-stage RGB565 per-channel blend unit, one pixel per cycle.
// ----------------------------------------------------------------------------
module crfab_blend
    import crfab_pkg::*;
#(
    parameter int AW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [AW-1:0] in_addr,
    input  logic [15:0]   bg,
    input  logic [15:0]   fg,
    input  logic [3:0]    alpha,
    output logic          out_vld,
    output logic [AW-1:0] out_addr,
    output logic [15:0]   out_color,
    output logic          active
);

    logic [3:0]    wb;
    logic [9:0]    r_sum_next, g_sum_next, b_sum_next;
    logic [9:0]    r_sum_reg, g_sum_reg, b_sum_reg;
    logic          s1_vld_reg, s2_vld_reg;
    logic [AW-1:0] s1_addr_reg, s2_addr_reg;
    logic [21:0]   r_prod, g_prod, b_prod;
    logic [15:0]   color_next, color_reg;

    assign wb = OPAQUE_LEVEL - alpha;

    assign r_sum_next = 10'(bg[15:11]) * 10'(wb) + 10'(fg[15:11]) * 10'(alpha);
    assign g_sum_next = 10'(bg[10:5])  * 10'(wb) + 10'(fg[10:5])  * 10'(alpha);
    assign b_sum_next = 10'(bg[4:0])   * 10'(wb) + 10'(fg[4:0])   * 10'(alpha);

    assign r_prod = 22'(r_sum_reg) * 22'(DIV15_RECIP);
    assign g_prod = 22'(g_sum_reg) * 22'(DIV15_RECIP);
    assign b_prod = 22'(b_sum_reg) * 22'(DIV15_RECIP);

    assign color_next = {r_prod[DIV15_SHIFT +: 5], g_prod[DIV15_SHIFT +: 6],
                         b_prod[DIV15_SHIFT +: 5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_sum_reg   <= r_sum_next;
        g_sum_reg   <= g_sum_next;
        b_sum_reg   <= b_sum_next;
        s1_addr_reg <= in_addr;
        s2_addr_reg <= s1_addr_reg;
        color_reg   <= color_next;
    end

    assign out_vld   = s2_vld_reg;
    assign out_addr  = s2_addr_reg;
    assign out_color = color_reg;
    assign active    = s1_vld_reg | s2_vld_reg;

endmodule

FILE: rtl/core/clipped_rect_fill_alpha_blend.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_alpha_blend
// Rectangle and vertical line fill with clipping and alpha blend over an
// RGB565 frame store, plus single pixel read.
// ----------------------------------------------------------------------------
//  channel   signals                               beat taken when
//  command   start, busy, request                  start && !busy
//  result    done, result                          done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
//  a draw scans the pixels of the clipped box (dotted gaps included), one
//  read-modify-write of the store per cycle; no pixel is scanned when the
//  box is clipped out or transparent
//  after reset the store is swept to zero, one address after another, with
//  busy high; config beats are taken at any time
//  the receiver cannot stall: each result shows for one cycle on done
// ----------------------------------------------------------------------------
module clipped_rect_fill_alpha_blend
    import crfab_pkg::*;
#(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              request,
    output logic              done,
    output res_t              result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(FB_WIDTH + 1);
    localparam int YW    = $clog2(FB_HEIGHT + 1);

    localparam coord_t        FBW_C = coord_t'(FB_WIDTH);
    localparam coord_t        FBH_C = coord_t'(FB_HEIGHT);
    localparam logic [AW-1:0] FBW_A = AW'(FB_WIDTH);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [7:0]  clip_x_min_reg, clip_x_max_reg;
    logic [6:0]  clip_y_min_reg, clip_y_max_reg;
    logic [11:0] origin_x_reg, origin_y_reg;

    req_t   req_reg, req_next;
    coord_t xo_reg, xo_next, yo_reg, yo_next;
    coord_t xs_reg, xs_next, xe_reg, xe_next;
    coord_t ys_reg, ys_next, ye_reg, ye_next;
    coord_t x0_reg, x0_next, x1_reg, x1_next;
    coord_t y0_reg, y0_next, y1_reg, y1_next;

    logic [XW-1:0] cx_reg, cx_next, xbeg_reg, xbeg_next, xend_reg, xend_next;
    logic [YW-1:0] cy_reg, cy_next, yend_reg, yend_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          par_reg, par_next;

    logic [13:0]   count_reg, count_next;
    logic          clipped_reg, clipped_next;
    logic [15:0]   rd_color_reg, rd_color_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          p1_vld_reg;
    logic [AW-1:0] p1_addr_reg;

    coord_t        xmin_l, xmax_l, ymin_l, ymax_l, w_s, h_s;
    logic          vline, issue, row_end;
    logic [XW-1:0] cx_inc;
    logic [YW-1:0] cy_inc;
    logic [AW-1:0] scan_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          b_vld, b_active;
    logic [AW-1:0] b_addr;
    logic [15:0]   b_color;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_min_reg <= '0;
            clip_x_max_reg <= CLIP_X_MAX_RST;
            clip_y_min_reg <= '0;
            clip_y_max_reg <= CLIP_Y_MAX_RST;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CLIP_X_MIN: clip_x_min_reg <= cfg_data[7:0];
                CFG_CLIP_X_MAX: clip_x_max_reg <= cfg_data[7:0];
                CFG_CLIP_Y_MIN: clip_y_min_reg <= cfg_data[6:0];
                CFG_CLIP_Y_MAX: clip_y_max_reg <= cfg_data[6:0];
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // clip window limited to the store
    assign xmin_l = (clip_x_min_reg > FB_WIDTH)  ? FBW_C : coord_t'(clip_x_min_reg);
    assign xmax_l = (clip_x_max_reg > FB_WIDTH)  ? FBW_C : coord_t'(clip_x_max_reg);
    assign ymin_l = (clip_y_min_reg > FB_HEIGHT) ? FBH_C : coord_t'(clip_y_min_reg);
    assign ymax_l = (clip_y_max_reg > FB_HEIGHT) ? FBH_C : coord_t'(clip_y_max_reg);

    assign vline = (req_reg.command == CMD_VLINE);
    assign w_s   = vline ? coord_t'(1) : sext12(req_reg.span_w);
    assign h_s   = sext12(req_reg.span_h);

    assign cx_inc    = cx_reg + 1'b1;
    assign cy_inc    = cy_reg + 1'b1;
    assign row_end   = (cx_inc == xend_reg);
    assign scan_addr = row_base_reg + AW'(cx_reg);
    assign issue     = (state_reg == ST_SCAN) && !(req_reg.pattern && par_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            p1_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            p1_vld_reg  <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        xo_reg       <= xo_next;
        yo_reg       <= yo_next;
        xs_reg       <= xs_next;
        xe_reg       <= xe_next;
        ys_reg       <= ys_next;
        ye_reg       <= ye_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        cx_reg       <= cx_next;
        xbeg_reg     <= xbeg_next;
        xend_reg     <= xend_next;
        cy_reg       <= cy_next;
        yend_reg     <= yend_next;
        row_base_reg <= row_base_next;
        par_reg      <= par_next;
        count_reg    <= count_next;
        clipped_reg  <= clipped_next;
        rd_color_reg <= rd_color_next;
        rd_ok_reg    <= rd_ok_next;
        rd_addr_reg  <= rd_addr_next;
        p1_addr_reg  <= scan_addr;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        xo_next       = xo_reg;
        yo_next       = yo_reg;
        xs_next       = xs_reg;
        xe_next       = xe_reg;
        ys_next       = ys_reg;
        ye_next       = ye_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        cx_next       = cx_reg;
        xbeg_next     = xbeg_reg;
        xend_next     = xend_reg;
        cy_next       = cy_reg;
        yend_next     = yend_reg;
        row_base_next = row_base_reg;
        par_next      = par_reg;
        count_next    = count_reg;
        clipped_next  = clipped_reg;
        rd_color_next = rd_color_reg;
        rd_ok_next    = rd_ok_reg;
        rd_addr_next  = rd_addr_reg;
        clr_cnt_next  = clr_cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = request;
                    count_next    = '0;
                    clipped_next  = 1'b0;
                    rd_color_next = '0;
                    state_next    = ST_OFFSET;
                end
            end
            ST_OFFSET:
            begin
                xo_next = sext12(req_reg.x_pos) + sext12(origin_x_reg);
                yo_next = sext12(req_reg.y_pos) + sext12(origin_y_reg);
                if (req_reg.command == CMD_READ)
                begin
                    state_next = ST_RADDR;
                end
                else if (req_reg.command == CMD_FILL || req_reg.command == CMD_VLINE)
                begin
                    state_next = ST_FLIP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FLIP:
            begin
                if (h_s < 0)
                begin
                    ys_next = yo_reg + h_s;
                    ye_next = yo_reg;
                end
                else
                begin
                    ys_next = yo_reg;
                    ye_next = yo_reg + h_s;
                end
                if (w_s < 0)
                begin
                    xs_next = xo_reg + w_s;
                    xe_next = xo_reg;
                end
                else
                begin
                    xs_next = xo_reg;
                    xe_next = xo_reg + w_s;
                end
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                x0_next    = (xs_reg > xmin_l) ? xs_reg : xmin_l;
                x1_next    = (xe_reg < xmax_l) ? xe_reg : xmax_l;
                y0_next    = (ys_reg > ymin_l) ? ys_reg : ymin_l;
                y1_next    = (ye_reg < ymax_l) ? ye_reg : ymax_l;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                clipped_next  = !((x1_reg > x0_reg) && (y1_reg > y0_reg));
                cx_next       = x0_reg[XW-1:0];
                xbeg_next     = x0_reg[XW-1:0];
                xend_next     = x1_reg[XW-1:0];
                cy_next       = y0_reg[YW-1:0];
                yend_next     = y1_reg[YW-1:0];
                row_base_next = AW'(y0_reg[YW-1:0]) * FBW_A;
                par_next      = 1'b0;
                if ((x1_reg > x0_reg) && (y1_reg > y0_reg) &&
                    (req_reg.opacity != OPAQUE_LEVEL))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RADDR:
            begin
                rd_ok_next   = (xo_reg >= 0) && (xo_reg < FBW_C) &&
                               (yo_reg >= 0) && (yo_reg < FBH_C);
                rd_addr_next = AW'(yo_reg[YW-1:0]) * FBW_A + AW'(xo_reg[XW-1:0]);
                state_next   = ST_RISSUE;
            end
            ST_RISSUE:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                rd_color_next = rd_ok_reg ? ram_rdata : 16'd0;
                state_next    = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (issue && count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                par_next = (row_end && !vline) ? 1'b0 : !par_reg;
                if (row_end)
                begin
                    cx_next       = xbeg_reg;
                    cy_next       = cy_inc;
                    row_base_next = row_base_reg + FBW_A;
                    if (cy_inc == yend_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    cx_next = cx_inc;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg && !b_active && !b_vld)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_raddr = (state_reg == ST_RISSUE) ? rd_addr_reg : scan_addr;
    assign ram_we    = (state_reg == ST_CLEAR) ? 1'b1 : b_vld;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : b_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 16'd0 : b_color;

    crfab_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crfab_blend #(
        .AW (AW)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (p1_vld_reg),
        .in_addr   (p1_addr_reg),
        .bg        (ram_rdata),
        .fg        (req_reg.fill_color),
        .alpha     (OPAQUE_LEVEL - req_reg.opacity),
        .out_vld   (b_vld),
        .out_addr  (b_addr),
        .out_color (b_color),
        .active    (b_active)
    );

    assign busy                  = (state_reg != ST_IDLE);
    assign done                  = (state_reg == ST_FINISH);
    assign result.read_color     = rd_color_reg;
    assign result.pixels_written = count_reg;
    assign result.clipped_out    = clipped_reg;

endmodule

FILE: rtl/core/crfab_checker.sv
// ----------------------------------------------------------------------------
// crfab_checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
module crfab_checker
    import crfab_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    // a result beat ends the command
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result beat");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a command");

    // read and draw results never mix
    a_read_or_draw: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.read_color == 16'd0) || (result.pixels_written == 14'd0))
        else $error("read colour and pixel count both non-zero");

    a_drawn_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.pixels_written != 14'd0)) |-> !result.clipped_out)
        else $error("pixels drawn on a clipped-out shape");

endmodule

bind clipped_rect_fill_alpha_blend crfab_checker u_crfab_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped rectangle fill and blend engine. A
// queue-fed driver issues draw, line and read commands while a shadow copy
// of the frame store and clip/origin registers computes each expected
// result. A monitor compares every result beat field by field. Runs go
// through several register settings and several sender gap rates.
// ----------------------------------------------------------------------------
module tb_top;
    import crfab_pkg::*;

    localparam int FB_W = 128;
    localparam int FB_H = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              request = '0;
    logic              done;
    res_t              result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_idx_t          cfg_index = CFG_CLIP_X_MIN;
    logic [CFG_DW-1:0] cfg_data = '0;

    logic [15:0] shadow_fb [0:FB_W*FB_H-1];
    int          clip_xmin = 0;
    int          clip_xmax = 128;
    int          clip_ymin = 0;
    int          clip_ymax = 64;
    int          org_x = 0;
    int          org_y = 0;

    req_t cmd_backlog [$];
    res_t answers_due [$];
    bit   holding = 1'b0;
    int   gap_pct = 0;
    int   mismatches = 0;

    clipped_rect_fill_alpha_blend #(
        .FB_WIDTH  (FB_W),
        .FB_HEIGHT (FB_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic logic [15:0] mix565(input logic [15:0] bg, input logic [15:0] fg,
                                           input int a);
        int wb;
        int rr;
        int gg;
        int bb;
        wb = 15 - a;
        rr = (int'(bg[15:11]) * wb + int'(fg[15:11]) * a) / 15;
        gg = (int'(bg[10:5]) * wb + int'(fg[10:5]) * a) / 15;
        bb = (int'(bg[4:0]) * wb + int'(fg[4:0]) * a) / 15;
        return {rr[4:0], gg[5:0], bb[4:0]};
    endfunction

    // updates the shadow store and queues the answer for one accepted command
    task automatic apply_draw_cmd(input req_t r);
        res_t o;
        int   px;
        int   py;
        int   w;
        int   h;
        int   xlo;
        int   xhi;
        int   ylo;
        int   yhi;
        int   i;
        int   j;
        int   k;
        int   a;
        int   cnt;
        int   addr;
        bit   vis;
        bit   vl;
        o = '0;
        cnt = 0;
        px = $signed(r.x_pos);
        py = $signed(r.y_pos);
        w = $signed(r.span_w);
        h = $signed(r.span_h);
        px = px + org_x;
        py = py + org_y;
        if (r.command == CMD_READ)
        begin
            if (px >= 0 && px < FB_W && py >= 0 && py < FB_H)
                o.read_color = shadow_fb[py * FB_W + px];
        end
        else if (r.command == CMD_FILL || r.command == CMD_VLINE)
        begin
            xlo = (clip_xmin > FB_W) ? FB_W : clip_xmin;
            xhi = (clip_xmax > FB_W) ? FB_W : clip_xmax;
            ylo = (clip_ymin > FB_H) ? FB_H : clip_ymin;
            yhi = (clip_ymax > FB_H) ? FB_H : clip_ymax;
            vl = (r.command == CMD_VLINE);
            if (vl)
                w = 1;
            if (h < 0)
            begin
                py = py + h;
                h = -h;
            end
            if (w < 0)
            begin
                px = px + w;
                w = -w;
            end
            if (px >= xhi || py >= yhi)
                vis = 1'b0;
            else
            begin
                if (py < ylo)
                begin
                    h = h + py - ylo;
                    py = ylo;
                end
                if (px < xlo)
                begin
                    w = w + px - xlo;
                    px = xlo;
                end
                if (py + h > yhi)
                    h = yhi - py;
                if (px + w > xhi)
                    w = xhi - px;
                vis = (h > 0 && w > 0);
            end
            o.clipped_out = !vis;
            if (vis && r.opacity != OPAQUE_LEVEL)
            begin
                a = int'(OPAQUE_LEVEL) - int'(r.opacity);
                for (i = 0; i < h; i++)
                begin
                    for (j = 0; j < w; j++)
                    begin
                        k = vl ? i : j;
                        if (r.pattern && k[0])
                            continue;
                        addr = (py + i) * FB_W + px + j;
                        if (r.opacity == 4'd0)
                            shadow_fb[addr] = r.fill_color;
                        else
                            shadow_fb[addr] = mix565(shadow_fb[addr], r.fill_color, a);
                        cnt++;
                    end
                end
            end
            o.pixels_written = (cnt > 16383) ? COUNT_MAX : cnt[13:0];
        end
        answers_due.push_back(o);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
            holding = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_draw_cmd(request);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    request <= cmd_backlog.pop_front();
                    start   <= 1'b1;
                    holding = 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch
        res_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                report_mismatch($sformatf("unexpected result %h", result));
            else
            begin
                want = answers_due.pop_front();
                if (result.read_color !== want.read_color)
                    report_mismatch($sformatf("read_color %h, want %h",
                                              result.read_color, want.read_color));
                if (result.pixels_written !== want.pixels_written)
                    report_mismatch($sformatf("pixels_written %0d, want %0d",
                                              result.pixels_written, want.pixels_written));
                if (result.clipped_out !== want.clipped_out)
                    report_mismatch($sformatf("clipped_out %b, want %b",
                                              result.clipped_out, want.clipped_out));
            end
        end
    end

    function automatic logic [11:0] to12(input int v);
        if (v > 2047)
            return 12'h7ff;
        if (v < -2048)
            return 12'h800;
        return v[11:0];
    endfunction

    function automatic req_t mk(input logic [1:0] c, input int x, input int y, input int w,
                                input int h, input logic [15:0] col, input logic [3:0] opa,
                                input logic pat);
        req_t r;
        r.command    = c;
        r.x_pos      = to12(x);
        r.y_pos      = to12(y);
        r.span_w     = to12(w);
        r.span_h     = to12(h);
        r.fill_color = col;
        r.opacity    = opa;
        r.pattern    = pat;
        return r;
    endfunction

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || holding || answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        logic signed [11:0] s12;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[11:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        s12 = val[11:0];
        case (idx)
            CFG_CLIP_X_MIN: clip_xmin = val & 'hff;
            CFG_CLIP_X_MAX: clip_xmax = val & 'hff;
            CFG_CLIP_Y_MIN: clip_ymin = val & 'h7f;
            CFG_CLIP_Y_MAX: clip_ymax = val & 'h7f;
            CFG_ORIGIN_X:   org_x = s12;
            CFG_ORIGIN_Y:   org_y = s12;
            default: ;
        endcase
    endtask

    task automatic set_window(input int x0, input int x1, input int y0, input int y1,
                              input int ox, input int oy);
        wait_idle();
        write_reg(CFG_CLIP_X_MIN, x0);
        write_reg(CFG_CLIP_X_MAX, x1);
        write_reg(CFG_CLIP_Y_MIN, y0);
        write_reg(CFG_CLIP_Y_MAX, y1);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
    endtask

    // one draw followed by reads around it, or a fully random command
    task automatic queue_burst(inout int n);
        req_t       r;
        logic [1:0] c;
        int         tx;
        int         ty;
        int         w;
        int         h;
        int         lx;
        int         ly;
        int         i;
        int         nrd;
        if ($urandom_range(0, 99) < 15)
        begin
            r.command    = 2'($urandom);
            r.x_pos      = 12'($urandom);
            r.y_pos      = 12'($urandom);
            r.span_w     = 12'($urandom);
            r.span_h     = 12'($urandom);
            r.fill_color = 16'($urandom);
            r.opacity    = 4'($urandom);
            r.pattern    = 1'($urandom);
            cmd_backlog.push_back(r);
            n++;
        end
        else
        begin
            tx = int'($urandom_range(0, 159)) - 16;
            ty = int'($urandom_range(0, 95)) - 16;
            if ($urandom_range(0, 9) == 0)
            begin
                w = int'($urandom_range(0, 300)) - 150;
                h = int'($urandom_range(0, 160)) - 80;
            end
            else
            begin
                w = int'($urandom_range(0, 40)) - 20;
                h = int'($urandom_range(0, 24)) - 12;
            end
            c = ($urandom_range(0, 3) == 0) ? CMD_VLINE : CMD_FILL;
            cmd_backlog.push_back(mk(c, tx - org_x, ty - org_y, w, h, 16'($urandom),
                                     ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom),
                                     1'($urandom)));
            n++;
            if (c == CMD_VLINE)
                w = 1;
            lx = (w < 0) ? tx + w : tx;
            ly = (h < 0) ? ty + h : ty;
            w = (w < 0) ? -w : w;
            h = (h < 0) ? -h : h;
            nrd = $urandom_range(1, 3);
            for (i = 0; i < nrd; i++)
            begin
                cmd_backlog.push_back(mk(CMD_READ,
                                         lx - 1 + int'($urandom_range(0, w + 1)) - org_x,
                                         ly - 1 + int'($urandom_range(0, h + 1)) - org_y,
                                         int'($urandom_range(0, 4095)) - 2048,
                                         int'($urandom_range(0, 4095)) - 2048,
                                         16'($urandom), 4'($urandom), 1'($urandom)));
                n++;
            end
        end
    endtask

    task automatic run_random(input int items, input int gap, input bit pause_midway);
        int n;
        n = 0;
        gap_pct = gap;
        while (n < items)
        begin
            queue_burst(n);
            if (pause_midway && n >= items / 2 && n < items / 2 + 4)
            begin
                wait_idle();
                pause_midway = 1'b0;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < FB_W * FB_H; i++)
            shadow_fb[i] = 16'h0000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        gap_pct = 0;
        cmd_backlog.push_back(mk(CMD_READ, 0, 0, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 0, 0, 2047, 2047, 16'hffff, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, -2048, -2048, 2047, 2047, 16'h1234, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 20, 20, -10, -5, 16'hf800, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 12, 14, 12, 8, 16'h07e0, 4'd7, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 0, 0, 5, 5, 16'h0f0f, 4'd15, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 200, 0, 5, 5, 16'h0f0f, 4'd15, 1'b1));
        cmd_backlog.push_back(mk(CMD_FILL, 3, 3, 0, 5, 16'h5555, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, 1, 30, 9, 3, 16'h001f, 4'd0, 1'b1));
        cmd_backlog.push_back(mk(CMD_VLINE, 50, 10, -2048, -9, 16'h8410, 4'd0, 1'b1));
        cmd_backlog.push_back(mk(CMD_VLINE, 127, 0, 0, 64, 16'h0000, 4'd1, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, -2048, -2048, -2048, -2048, 16'hffff, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_UNUSED, -1, -1, -1, -1, 16'hffff, 4'hf, 1'b1));
        cmd_backlog.push_back(mk(CMD_READ, 12, 14, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_READ, 50, 2, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_READ, 127, 63, -1, -1, 16'hffff, 4'hf, 1'b1));
        cmd_backlog.push_back(mk(CMD_READ, 128, 0, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_READ, 0, 64, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_READ, 2047, 2047, 0, 0, 16'h0000, 4'd0, 1'b0));
        wait_idle();

        run_random(20, 0, 1'b0);

        set_window(16, 112, 8, 56, 5, -3);
        run_random(20, 77, 1'b0);

        // clip edges beyond the store, origin at its extremes
        set_window(0, 255, 0, 127, 2047, -2048);
        gap_pct = 0;
        cmd_backlog.push_back(mk(CMD_FILL, -2040, 2047, 200, 100, 16'h7bef, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_FILL, -1930, 2047, -30, 70, 16'hffe0, 4'd9, 1'b1));
        cmd_backlog.push_back(mk(CMD_READ, -2047, 2047, 0, 0, 16'h0000, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_READ, -1950, 2047, 0, 0, 16'h0000, 4'd0, 1'b0));
        wait_idle();

        // inverted window
        set_window(255, 20, 127, 10, -7, 4);
        cmd_backlog.push_back(mk(CMD_FILL, 0, 0, 2047, 2047, 16'hffff, 4'd0, 1'b0));
        cmd_backlog.push_back(mk(CMD_VLINE, 10, 0, 1, 60, 16'hffff, 4'd15, 1'b0));
        wait_idle();
        write_reg(CFG_CLIP_X_MIN, 100);
        cmd_backlog.push_back(mk(CMD_FILL, 0, 0, 2047, 2047, 16'hffff, 4'd3, 1'b1));
        wait_idle();

        set_window(3, 128, 1, 64, -10, 6);
        run_random(20, 0, 1'b0);
        run_random(20, 18, 1'b1);

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
